// ===== hdl/sfe_pkg.sv =====
// Shared types, constants and lookup functions for the four-digit segment
// frame encoder. No dependencies; used by every module in hdl/.
package sfe_pkg;

   // display modes carried in the cmd field
   localparam logic [1:0] CMD_PLAIN = 2'd0;
   localparam logic [1:0] CMD_TEMP  = 2'd1;
   localparam logic [1:0] CMD_VOLT  = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [13:0] SAT_LIMIT     = 14'd9999;
   localparam logic [10:0] RECIP_1000    = 11'd1048;   // floor(2^20 / 1000)
   localparam int          RECIP_SHIFT   = 20;
   localparam logic [7:0]  DP_MASK       = 8'h7F;
   localparam logic [7:0]  CELSIUS_GLYPH = 8'hC6;
   localparam logic [7:0]  BLANK_GLYPH   = 8'hFF;
   localparam logic [1:0]  LAST_FRAME    = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] value;
      logic [15:0] hold_ms;
   } req_type;

   typedef struct packed {
      logic [7:0]  segments;
      logic [7:0]  digit_select;
      logic [15:0] frame_hold_ms;
      logic        overflow;
      logic        last;
   } rsp_type;

   // one decoded item waiting for the frame sequencer
   typedef struct packed {
      logic [3:0][7:0] segments;
      logic [15:0]     hold_ms;
      logic            overflow;
   } entry_type;

   // active-low segment code of a decimal digit, bit 7 is the decimal point
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = BLANK_GLYPH;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] sel_code(input logic [1:0] frame);
      logic [7:0] code;
      unique case (frame)
         2'd0:    code = 8'h1F;
         2'd1:    code = 8'h2F;
         2'd2:    code = 8'h4F;
         default: code = 8'h8F;
      endcase
      return code;
   endfunction

   // leading decimal digit of x for a place weight of step (x < 10 * step):
   // nine parallel compares, the highest one that passes wins
   function automatic logic [3:0] dec_digit(input logic [13:0] x,
                                            input logic [13:0] step);
      logic [3:0] d;
      d = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (x >= 14'(14'(k) * step)) begin
            d = 4'(k);
         end
      end
      return d;
   endfunction

endpackage

// ===== hdl/sfe_front.sv =====
// Front end: accepts requests and turns value/mode into four segment bytes.
// Three register stages: reciprocal product, clamp or mod 1000, thousands split.
// Depends on sfe_pkg.
module sfe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  sfe_pkg::req_type    req_data,
   output logic                q_push,
   input  logic                q_full,
   output sfe_pkg::entry_type  q_data
);

   logic        enable;

   // stage 1
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_cmd_ff;
   logic [15:0] s1_value_ff;
   logic [15:0] s1_hold_ff;
   logic [26:0] s1_prod_ff, s1_prod_in;

   // stage 2
   logic        s2_valid_ff;
   logic [1:0]  s2_cmd_ff;
   logic [13:0] s2_t_ff, s2_t_in;
   logic [15:0] s2_hold_ff;
   logic        s2_ovf_ff, s2_ovf_in;
   logic [6:0]  quot;
   logic [15:0] mod_raw;
   logic [10:0] mod_fix;

   // stage 3
   logic        s3_valid_ff;
   logic [1:0]  s3_cmd_ff;
   logic [3:0]  s3_d3_ff, s3_d3_in;
   logic [9:0]  s3_r1_ff, s3_r1_in;
   logic [15:0] s3_hold_ff;
   logic        s3_ovf_ff;

   // output-side split
   logic [3:0]  d2, d1, d0;
   logic [6:0]  r2;
   logic [7:0]  seg0, seg1, seg2, seg3;

   // whole pipe advances together; it only stops when the queue is full
   assign enable   = !(s3_valid_ff && q_full);
   assign req_full = !enable;

   assign s1_valid_in = req_push;
   assign s1_prod_in  = 27'(req_data.value) * 27'(sfe_pkg::RECIP_1000);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_cmd_ff   <= req_data.cmd;
         s1_value_ff <= req_data.value;
         s1_hold_ff  <= req_data.hold_ms;
         s1_prod_ff  <= s1_prod_in;

         s2_cmd_ff   <= s1_cmd_ff;
         s2_t_ff     <= s2_t_in;
         s2_hold_ff  <= s1_hold_ff;
         s2_ovf_ff   <= s2_ovf_in;

         s3_cmd_ff   <= s2_cmd_ff;
         s3_d3_ff    <= s3_d3_in;
         s3_r1_ff    <= s3_r1_in;
         s3_hold_ff  <= s2_hold_ff;
         s3_ovf_ff   <= s2_ovf_ff;
      end
   end

   // the reciprocal underestimates the quotient by at most one
   always_comb begin
      quot    = s1_prod_ff[sfe_pkg::RECIP_SHIFT +: 7];
      mod_raw = s1_value_ff - 16'(16'(quot) * 16'd1000);
      mod_fix = (mod_raw[10:0] >= 11'd1000) ? 11'(mod_raw[10:0] - 11'd1000)
                                            : mod_raw[10:0];
      s2_ovf_in = (s1_cmd_ff != sfe_pkg::CMD_TEMP) &&
                  (s1_value_ff > 16'(sfe_pkg::SAT_LIMIT));
      if (s1_cmd_ff == sfe_pkg::CMD_TEMP) begin
         s2_t_in = 14'(mod_fix);
      end else if (s2_ovf_in) begin
         s2_t_in = sfe_pkg::SAT_LIMIT;
      end else begin
         s2_t_in = s1_value_ff[13:0];
      end
   end

   always_comb begin
      s3_d3_in = sfe_pkg::dec_digit(s2_t_ff, 14'd1000);
      s3_r1_in = 10'(s2_t_ff - 14'(14'(s3_d3_in) * 14'd1000));
   end

   always_comb begin
      d2 = sfe_pkg::dec_digit(14'(s3_r1_ff), 14'd100);
      r2 = 7'(s3_r1_ff - 10'(10'(d2) * 10'd100));
      d1 = sfe_pkg::dec_digit(14'(r2), 14'd10);
      d0 = 4'(r2 - 7'(7'(d1) * 7'd10));

      if (s3_cmd_ff == sfe_pkg::CMD_TEMP) begin
         seg0 = sfe_pkg::seg_code(d2);
         seg1 = sfe_pkg::seg_code(d1) & sfe_pkg::DP_MASK;
         seg2 = sfe_pkg::seg_code(d0);
         seg3 = sfe_pkg::CELSIUS_GLYPH;
      end else begin
         seg0 = sfe_pkg::seg_code(s3_d3_ff);
         seg1 = sfe_pkg::seg_code(d2);
         seg2 = sfe_pkg::seg_code(d1);
         seg3 = sfe_pkg::seg_code(d0);
         if (s3_cmd_ff == sfe_pkg::CMD_VOLT) begin
            seg2 = seg2 & sfe_pkg::DP_MASK;
         end
      end

      q_data.segments = {seg3, seg2, seg1, seg0};
      q_data.hold_ms  = s3_hold_ff;
      q_data.overflow = s3_ovf_ff;
   end

   assign q_push = s3_valid_ff && !q_full;

endmodule

// ===== hdl/sfe_queue.sv =====
// Small register FIFO between the decode front end and the frame sequencer.
// Depends on sfe_pkg.
module sfe_queue #(
   parameter int Depth = sfe_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  sfe_pkg::entry_type  push_data,
   input  logic                pop,
   output logic                empty,
   output sfe_pkg::entry_type  pop_data
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   sfe_pkg::entry_type    slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = (count_ff == CountWidth'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : PtrWidth'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : PtrWidth'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CountWidth'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CountWidth'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/sfe_back.sv =====
// Back end: takes one decoded item from the queue and plays out its four
// digit frames on the result port. Depends on sfe_pkg.
module sfe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  sfe_pkg::entry_type  q_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output sfe_pkg::rsp_type    rsp_data
);

   logic               valid_ff, valid_in;
   logic [1:0]         frame_ff, frame_in;
   sfe_pkg::entry_type entry_ff;
   logic               taken, frame_done, take_next;

   assign taken      = valid_ff && rsp_pop;
   assign frame_done = taken && (frame_ff == sfe_pkg::LAST_FRAME);
   // the holding register frees up when empty or when its last frame leaves
   assign take_next  = !valid_ff || frame_done;
   assign q_pop      = take_next && !q_empty;

   always_comb begin
      valid_in = valid_ff;
      frame_in = frame_ff;
      if (take_next) begin
         valid_in = !q_empty;
         frame_in = 2'd0;
      end else if (taken) begin
         frame_in = 2'(frame_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         frame_ff <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         entry_ff <= q_data;
      end
   end

   assign rsp_empty = !valid_ff;

   always_comb begin
      rsp_data.segments      = entry_ff.segments[frame_ff];
      rsp_data.digit_select  = sfe_pkg::sel_code(frame_ff);
      rsp_data.frame_hold_ms = entry_ff.hold_ms;
      rsp_data.overflow      = entry_ff.overflow;
      rsp_data.last          = (frame_ff == sfe_pkg::LAST_FRAME);
   end

endmodule

// ===== hdl/four_digit_segment_frame_encoder.sv =====
// Four-digit segment frame encoder: top level tying front end, queue and back end.
// Depends on sfe_pkg, sfe_front, sfe_queue, sfe_back.
//
// Each request (cmd, value, hold_ms) yields four result frames, digit 0 first,
// the fourth flagged last. The frame sequencer hands out one frame per cycle
// while rsp_pop is held high, on the single result port. A request, once
// accepted, is registered in the three decode stages in turn, then written
// into the queue, then loaded into the sequencer's holding register, from
// which its first frame is shown on the result port. The decode front end keeps
// taking requests while frames are being popped, until the queue of
// QueueDepth decoded items is full and the last decode stage holds another;
// only then does req_full rise.
module four_digit_segment_frame_encoder #(
   parameter int QueueDepth = sfe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sfe_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sfe_pkg::rsp_type rsp_data
);

   logic               q_push, q_full, q_pop, q_empty;
   sfe_pkg::entry_type q_wr_data, q_rd_data;

   sfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wr_data)
   );

   sfe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rd_data)
   );

   sfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (q_rd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // the last frame always lands on the fourth digit
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last) |-> (rsp_data.digit_select == sfe_pkg::sel_code(2'd3)))
      else $error("last frame not on digit 3");

   // frames of one request follow each other without a gap
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=>
         (!rsp_empty && rsp_data.frame_hold_ms == $past(rsp_data.frame_hold_ms)
          && rsp_data.overflow == $past(rsp_data.overflow)))
      else $error("request frames split or mixed");

   // a saturated value shows 9 on every digit
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.overflow) |-> (rsp_data.segments[6:0] == 7'h10))
      else $error("overflow frame not showing 9");
`endif

endmodule
